/* src/sha512_pkg.sv */
`default_nettype none

package sha512_pkg;

  // One 64-bit word and the eight working variables, index 0 is a
  typedef logic [63:0] word_t;
  typedef logic [7:0][63:0] vars_t;

  // Input word: message bytes plus framing
  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
  } in_word_t;

  // Output word: one digest word and its position
  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;
  } out_word_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_HADD,
    ST_PAD,
    ST_OUT
  } state_e;

  localparam int unsigned ROUNDS      = 80;
  localparam int unsigned RND_W       = $clog2(ROUNDS);
  localparam int unsigned WIN_DEPTH   = 16;
  localparam int unsigned POS_W       = $clog2(WIN_DEPTH);
  localparam int unsigned BYTES_WORD  = 8;
  localparam int unsigned DIGEST_W    = 8;
  localparam int unsigned IDX_W       = $clog2(DIGEST_W);

  localparam logic [RND_W-1:0] RND_LAST  = RND_W'(ROUNDS - 1);
  localparam logic [POS_W-1:0] POS_BLOCK = POS_W'(WIN_DEPTH - 1);
  localparam logic [POS_W-1:0] POS_LEN   = POS_W'(WIN_DEPTH - 2);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DIGEST_W - 1);
  localparam logic [3:0]       VB_FULL   = 4'(BYTES_WORD);

  localparam word_t PAD_MARK = 64'h8000_0000_0000_0000;

  // Initial hash, written h down to a so that index 0 holds a
  localparam vars_t HASH_INIT = {
    64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b,
    64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
    64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b,
    64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  // Round constants
  function automatic word_t round_k(logic [RND_W-1:0] t);
    case (t)
      7'd0:  round_k = 64'h428a2f98d728ae22;
      7'd1:  round_k = 64'h7137449123ef65cd;
      7'd2:  round_k = 64'hb5c0fbcfec4d3b2f;
      7'd3:  round_k = 64'he9b5dba58189dbbc;
      7'd4:  round_k = 64'h3956c25bf348b538;
      7'd5:  round_k = 64'h59f111f1b605d019;
      7'd6:  round_k = 64'h923f82a4af194f9b;
      7'd7:  round_k = 64'hab1c5ed5da6d8118;
      7'd8:  round_k = 64'hd807aa98a3030242;
      7'd9:  round_k = 64'h12835b0145706fbe;
      7'd10: round_k = 64'h243185be4ee4b28c;
      7'd11: round_k = 64'h550c7dc3d5ffb4e2;
      7'd12: round_k = 64'h72be5d74f27b896f;
      7'd13: round_k = 64'h80deb1fe3b1696b1;
      7'd14: round_k = 64'h9bdc06a725c71235;
      7'd15: round_k = 64'hc19bf174cf692694;
      7'd16: round_k = 64'he49b69c19ef14ad2;
      7'd17: round_k = 64'hefbe4786384f25e3;
      7'd18: round_k = 64'h0fc19dc68b8cd5b5;
      7'd19: round_k = 64'h240ca1cc77ac9c65;
      7'd20: round_k = 64'h2de92c6f592b0275;
      7'd21: round_k = 64'h4a7484aa6ea6e483;
      7'd22: round_k = 64'h5cb0a9dcbd41fbd4;
      7'd23: round_k = 64'h76f988da831153b5;
      7'd24: round_k = 64'h983e5152ee66dfab;
      7'd25: round_k = 64'ha831c66d2db43210;
      7'd26: round_k = 64'hb00327c898fb213f;
      7'd27: round_k = 64'hbf597fc7beef0ee4;
      7'd28: round_k = 64'hc6e00bf33da88fc2;
      7'd29: round_k = 64'hd5a79147930aa725;
      7'd30: round_k = 64'h06ca6351e003826f;
      7'd31: round_k = 64'h142929670a0e6e70;
      7'd32: round_k = 64'h27b70a8546d22ffc;
      7'd33: round_k = 64'h2e1b21385c26c926;
      7'd34: round_k = 64'h4d2c6dfc5ac42aed;
      7'd35: round_k = 64'h53380d139d95b3df;
      7'd36: round_k = 64'h650a73548baf63de;
      7'd37: round_k = 64'h766a0abb3c77b2a8;
      7'd38: round_k = 64'h81c2c92e47edaee6;
      7'd39: round_k = 64'h92722c851482353b;
      7'd40: round_k = 64'ha2bfe8a14cf10364;
      7'd41: round_k = 64'ha81a664bbc423001;
      7'd42: round_k = 64'hc24b8b70d0f89791;
      7'd43: round_k = 64'hc76c51a30654be30;
      7'd44: round_k = 64'hd192e819d6ef5218;
      7'd45: round_k = 64'hd69906245565a910;
      7'd46: round_k = 64'hf40e35855771202a;
      7'd47: round_k = 64'h106aa07032bbd1b8;
      7'd48: round_k = 64'h19a4c116b8d2d0c8;
      7'd49: round_k = 64'h1e376c085141ab53;
      7'd50: round_k = 64'h2748774cdf8eeb99;
      7'd51: round_k = 64'h34b0bcb5e19b48a8;
      7'd52: round_k = 64'h391c0cb3c5c95a63;
      7'd53: round_k = 64'h4ed8aa4ae3418acb;
      7'd54: round_k = 64'h5b9cca4f7763e373;
      7'd55: round_k = 64'h682e6ff3d6b2b8a3;
      7'd56: round_k = 64'h748f82ee5defb2fc;
      7'd57: round_k = 64'h78a5636f43172f60;
      7'd58: round_k = 64'h84c87814a1f0ab72;
      7'd59: round_k = 64'h8cc702081a6439ec;
      7'd60: round_k = 64'h90befffa23631e28;
      7'd61: round_k = 64'ha4506cebde82bde9;
      7'd62: round_k = 64'hbef9a3f7b2c67915;
      7'd63: round_k = 64'hc67178f2e372532b;
      7'd64: round_k = 64'hca273eceea26619c;
      7'd65: round_k = 64'hd186b8c721c0c207;
      7'd66: round_k = 64'heada7dd6cde0eb1e;
      7'd67: round_k = 64'hf57d4f7fee6ed178;
      7'd68: round_k = 64'h06f067aa72176fba;
      7'd69: round_k = 64'h0a637dc5a2c898a6;
      7'd70: round_k = 64'h113f9804bef90dae;
      7'd71: round_k = 64'h1b710b35131c471b;
      7'd72: round_k = 64'h28db77f523047d84;
      7'd73: round_k = 64'h32caab7b40c72493;
      7'd74: round_k = 64'h3c9ebe0a15c9bebc;
      7'd75: round_k = 64'h431d67c49c100d4c;
      7'd76: round_k = 64'h4cc5d4becb3e42b6;
      7'd77: round_k = 64'h597f299cfc657e2a;
      7'd78: round_k = 64'h5fcb6fab3ad6faec;
      7'd79: round_k = 64'h6c44198c4a475817;
      default: round_k = '0;
    endcase
  endfunction

endpackage

`default_nettype wire

/* src/sha512_round.sv */
`default_nettype none

// One compression round plus one schedule extension step
module sha512_round (
  input  sha512_pkg::vars_t vars_i,
  input  sha512_pkg::word_t k_i,
  input  sha512_pkg::word_t w0_i,
  input  sha512_pkg::word_t w1_i,
  input  sha512_pkg::word_t w9_i,
  input  sha512_pkg::word_t w14_i,
  output sha512_pkg::vars_t vars_o,
  output sha512_pkg::word_t wnext_o
);
  import sha512_pkg::*;

  word_t big_s0, big_s1, ch, maj, t1, t2, sm0, sm1;

  // Round function on a..h, w0 is the schedule word of this round
  always_comb begin
    big_s1 = rotr(vars_i[4], 14) ^ rotr(vars_i[4], 18) ^ rotr(vars_i[4], 41);
    big_s0 = rotr(vars_i[0], 28) ^ rotr(vars_i[0], 34) ^ rotr(vars_i[0], 39);
    ch     = (vars_i[4] & vars_i[5]) ^ (~vars_i[4] & vars_i[6]);
    maj    = (vars_i[0] & vars_i[1]) ^ (vars_i[0] & vars_i[2]) ^ (vars_i[1] & vars_i[2]);
    t1     = vars_i[7] + big_s1 + ch + k_i + w0_i;
    t2     = big_s0 + maj;
    vars_o[7] = vars_i[6];
    vars_o[6] = vars_i[5];
    vars_o[5] = vars_i[4];
    vars_o[4] = vars_i[3] + t1;
    vars_o[3] = vars_i[2];
    vars_o[2] = vars_i[1];
    vars_o[1] = vars_i[0];
    vars_o[0] = t1 + t2;
  end

  // Schedule word sixteen rounds ahead
  always_comb begin
    sm1     = rotr(w14_i, 19) ^ rotr(w14_i, 61) ^ (w14_i >> 6);
    sm0     = rotr(w1_i, 1) ^ rotr(w1_i, 8) ^ (w1_i >> 7);
    wnext_o = sm1 + w9_i + sm0 + w0_i;
  end

endmodule

`default_nettype wire

/* src/sha512_hash_core.sv */
`default_nettype none

// SHA-512 hash core.
// Input channel (in_valid_i/in_ready_o/in_word_i): big-endian 64-bit message
// words, first byte in the top byte. valid_bytes counts the leading valid
// bytes of the last word (values above 8 count as 8); on other words all
// eight bytes are taken. last_word closes the message.
// Output channel (out_valid_o/out_ready_i/out_word_o): the eight digest
// words, word_index 0 first, digest_last on the eighth.
// Timing: words that do not close a 1024-bit block are accepted one per cycle
// while in_ready_o is high. The sixteenth word of a block starts the 80 rounds
// on the single round unit and then the hash update. After the last word,
// padding words are shifted in one per cycle (up to 17), with one or two
// compressions, before the first digest word is offered.
// in_ready_o is low while a block is compressed and from the last word until
// the last digest word is taken. A stalled receiver holds the digest word
// steady; nothing is lost.
// Reset loads the initial hash and clears the length count and position;
// after the eighth digest word the same happens and a new message begins.
module sha512_hash_core (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  sha512_pkg::in_word_t  in_word_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output sha512_pkg::out_word_t out_word_o
);
  import sha512_pkg::*;

  state_e             state_q, state_d;
  logic [RND_W-1:0]   rnd_q, rnd_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  word_t              cnt_q, cnt_d;
  vars_t              hash_q, hash_d;
  vars_t              wv_q, wv_d;
  logic [WIN_DEPTH-1:0][63:0] win_q, win_d;
  logic               extra_q, extra_d;
  logic               armed_q, armed_d;
  logic               pad_q, pad_d;
  logic               fin_q, fin_d;

  logic               in_acc, out_acc;
  logic               push_en, round_en, hadd_en, blk_done;
  word_t              push_word;
  logic [3:0]         vb_clip;
  logic [63:0]        byte_mask;
  word_t              last_data;
  vars_t              rnd_vars;
  word_t              rnd_wnext;
  int unsigned        i;

  // Shared round unit
  sha512_round u_round (
    .vars_i  (wv_q),
    .k_i     (round_k(rnd_q)),
    .w0_i    (win_q[0]),
    .w1_i    (win_q[1]),
    .w9_i    (win_q[9]),
    .w14_i   (win_q[14]),
    .vars_o  (rnd_vars),
    .wnext_o (rnd_wnext)
  );

  // Handshake and unit enables
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    round_en    = 1'b0;
    hadd_en     = 1'b0;
    case (state_q)
      ST_IDLE:  in_ready_o  = 1'b1;
      ST_ROUND: round_en    = 1'b1;
      ST_HADD:  hadd_en     = 1'b1;
      ST_OUT:   out_valid_o = 1'b1;
      default: ;
    endcase
    in_acc   = in_valid_i & in_ready_o;
    out_acc  = out_valid_o & out_ready_i;
    push_en  = in_acc | (state_q == ST_PAD);
    blk_done = push_en & (pos_q == POS_BLOCK);
  end

  // Last word: keep valid bytes, put the marker byte right after them
  always_comb begin
    vb_clip   = (in_word_i.valid_bytes > VB_FULL) ? VB_FULL : in_word_i.valid_bytes;
    byte_mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> {vb_clip, 3'b000});
    last_data = in_word_i.data_word & byte_mask;
    if (vb_clip != VB_FULL) begin
      last_data = last_data | (PAD_MARK >> {vb_clip, 3'b000});
    end
  end

  // Word shifted into the schedule window
  always_comb begin
    if (state_q == ST_PAD) begin
      if (extra_q) begin
        push_word = PAD_MARK;
      end else if (armed_q) begin
        push_word = cnt_q;
      end else begin
        push_word = '0;
      end
    end else if (in_word_i.last_word) begin
      push_word = last_data;
    end else begin
      push_word = in_word_i.data_word;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (blk_done) begin
            state_d = ST_ROUND;
          end else if (in_word_i.last_word) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (rnd_q == RND_LAST) begin
          state_d = ST_HADD;
        end
      end
      ST_HADD: begin
        if (fin_q) begin
          state_d = ST_OUT;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PAD: begin
        if (blk_done) begin
          state_d = ST_ROUND;
        end
      end
      ST_OUT: begin
        if (out_acc && idx_q == IDX_LAST) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and flag updates
  always_comb begin
    rnd_d   = rnd_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    hash_d  = hash_q;
    wv_d    = wv_q;
    win_d   = win_q;
    extra_d = extra_q;
    armed_d = armed_q;
    pad_d   = pad_q;
    fin_d   = fin_q;

    // message length in bits
    if (in_acc) begin
      if (in_word_i.last_word) begin
        cnt_d   = cnt_q + {57'd0, vb_clip, 3'b000};
        pad_d   = 1'b1;
        extra_d = (vb_clip == VB_FULL);
      end else begin
        cnt_d = cnt_q + 64'd64;
      end
    end

    // padding sequence: marker word if needed, zeros, length at the last slot
    if (state_q == ST_PAD) begin
      if (extra_q) begin
        extra_d = 1'b0;
      end else if (armed_q) begin
        armed_d = 1'b0;
        pad_d   = 1'b0;
        fin_d   = 1'b1;
      end else if (pos_q == POS_LEN) begin
        armed_d = 1'b1;
      end
    end

    // schedule window shift
    if (push_en || round_en) begin
      for (i = 0; i < WIN_DEPTH - 1; i++) begin
        win_d[i] = win_q[i + 1];
      end
      win_d[WIN_DEPTH-1] = push_en ? push_word : rnd_wnext;
    end

    if (push_en) begin
      pos_d = pos_q + 1'b1;
    end
    if (blk_done) begin
      wv_d  = hash_q;
      rnd_d = '0;
    end

    if (round_en) begin
      wv_d  = rnd_vars;
      rnd_d = rnd_q + 1'b1;
    end

    if (hadd_en) begin
      for (i = 0; i < DIGEST_W; i++) begin
        hash_d[i] = hash_q[i] + wv_q[i];
      end
    end

    // digest readout, then start a fresh message
    if (out_acc) begin
      idx_d = idx_q + 1'b1;
      if (idx_q == IDX_LAST) begin
        hash_d = HASH_INIT;
        cnt_d  = '0;
        pos_d  = '0;
        fin_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rnd_q   <= '0;
      pos_q   <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      hash_q  <= HASH_INIT;
      wv_q    <= '0;
      extra_q <= 1'b0;
      armed_q <= 1'b0;
      pad_q   <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      hash_q  <= hash_d;
      wv_q    <= wv_d;
      extra_q <= extra_d;
      armed_q <= armed_d;
      pad_q   <= pad_d;
      fin_q   <= fin_d;
    end
  end

  // Schedule window holds no reset, every slot is written before use
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  // Output word
  always_comb begin
    out_word_o.digest_word = hash_q[idx_q];
    out_word_o.word_index  = idx_q;
    out_word_o.digest_last = (idx_q == IDX_LAST);
  end

endmodule

`default_nettype wire
